// File: hw/rtl/rm2q_pkg.sv
package rm2q_pkg;

    // Number formats
    localparam int FRAC_BITS  = 14;
    localparam int DATA_WIDTH = 16;
    localparam int EPS_W      = 15;
    localparam int LANES      = 3;

    // Trace / radicand width (sum of three elements plus one, signed)
    localparam int T_W    = DATA_WIDTH + 2;
    // Positive radicand shifted up by the fraction bits
    localparam int V_W    = T_W - 1 + FRAC_BITS;
    localparam int ROOT_W = (V_W + 1) / 2;
    localparam int SQ_W   = 2 * ROOT_W + 1;
    // Numerator magnitude (difference or sum of two elements)
    localparam int NUM_W  = DATA_WIDTH + 1;
    localparam int S_W    = ROOT_W + 1;
    localparam int QB     = DATA_WIDTH;
    localparam int DIVD_W = NUM_W + FRAC_BITS;
    localparam int CMP_W  = ((DIVD_W > S_W + QB) ? DIVD_W : S_W + QB) + 1;

    // Branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    // Sideband carried alongside the square root
    typedef struct packed {
        logic [1:0]                       branch;
        logic                             nonpos;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0][NUM_W-1:0]      mag;
    } rm2q_side_t;

    // Result of the divider stage
    typedef struct packed {
        logic [1:0]                       branch;
        logic                             nonpos;
        logic [ROOT_W-1:0]                root;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0]                 ovf;
        logic [LANES-1:0][QB-1:0]         q;
    } rm2q_quo_t;

endpackage

// File: hw/rtl/rm2q_front.sv
module rm2q_front
    import rm2q_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    input  logic [EPS_W-1:0]             eps,
    output logic                         out_valid,
    output logic [V_W-1:0]               out_rad,
    output rm2q_side_t                   out_side,
    input  logic                         out_ready
);

    localparam logic signed [T_W-1:0] ONE = T_W'(1) <<< FRAC_BITS;

    logic                        v_reg;
    logic [V_W-1:0]              rad_reg;
    rm2q_side_t                  side_reg;

    logic signed [T_W-1:0]       e00, e11, e22, t, rad, eps_s;
    logic signed [NUM_W-1:0]     na, nb, nc, np, nq, nr;
    logic signed [NUM_W-1:0]     lane [LANES];
    logic [1:0]                  br;
    rm2q_side_t                  side_next;
    logic [V_W-1:0]              rad_next;

    assign in_ready = !v_reg || out_ready;

    // Trace test, branch select and radicand
    always_comb
    begin
        e00   = T_W'(m00);
        e11   = T_W'(m11);
        e22   = T_W'(m22);
        eps_s = $signed({{(T_W-EPS_W){1'b0}}, eps});
        t     = e00 + e11 + e22 + ONE;
        if (t > eps_s)
        begin
            br  = BR_TRACE;
            rad = t;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            br  = BR_X;
            rad = ONE + e00 - e11 - e22;
        end
        else if (m11 > m22)
        begin
            br  = BR_Y;
            rad = ONE + e11 - e00 - e22;
        end
        else
        begin
            br  = BR_Z;
            rad = ONE + e22 - e00 - e11;
        end
        rad_next = {rad[T_W-2:0], {FRAC_BITS{1'b0}}};
    end

    // Numerators, routed to the three divider lanes
    always_comb
    begin
        na = NUM_W'(m21) - NUM_W'(m12);
        nb = NUM_W'(m02) - NUM_W'(m20);
        nc = NUM_W'(m10) - NUM_W'(m01);
        np = NUM_W'(m01) + NUM_W'(m10);
        nq = NUM_W'(m02) + NUM_W'(m20);
        nr = NUM_W'(m12) + NUM_W'(m21);
        case (br)
            BR_TRACE: begin lane[0] = na; lane[1] = nb; lane[2] = nc; end
            BR_X:     begin lane[0] = np; lane[1] = nq; lane[2] = na; end
            BR_Y:     begin lane[0] = np; lane[1] = nr; lane[2] = nb; end
            default:  begin lane[0] = nq; lane[1] = nr; lane[2] = nc; end
        endcase
        side_next.branch = br;
        side_next.nonpos = (rad <= 0);
        for (int l = 0; l < LANES; l++)
        begin
            side_next.neg[l] = lane[l][NUM_W-1];
            side_next.mag[l] = lane[l][NUM_W-1] ? NUM_W'(-lane[l]) : NUM_W'(lane[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/rm2q_sqrt.sv
module rm2q_sqrt
    import rm2q_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [V_W-1:0]    in_rad,
    input  rm2q_side_t        in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output rm2q_side_t        out_side,
    input  logic              out_ready
);

    localparam int N = ROOT_W;

    logic [N-1:0]      v_reg;
    logic [SQ_W-1:0]   rem_reg  [N];
    logic [ROOT_W-1:0] res_reg  [N];
    rm2q_side_t        side_reg [N];

    logic [N:0]        rdy;
    logic [N-1:0]      p_v;
    logic [SQ_W-1:0]   p_rem    [N];
    logic [ROOT_W-1:0] p_res    [N];
    rm2q_side_t        p_side   [N];
    logic [SQ_W-1:0]   inc      [N];

    // A stage moves when it is empty or the next one moves
    always_comb
    begin
        rdy[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    // Stage inputs and trial increment: (res + 2^b)^2 - res^2
    always_comb
    begin
        p_v[0]    = in_valid;
        p_rem[0]  = SQ_W'(in_rad);
        p_res[0]  = '0;
        p_side[0] = in_side;
        for (int k = 1; k < N; k++)
        begin
            p_v[k]    = v_reg[k-1];
            p_rem[k]  = rem_reg[k-1];
            p_res[k]  = res_reg[k-1];
            p_side[k] = side_reg[k-1];
        end
        for (int k = 0; k < N; k++)
            inc[k] = (SQ_W'(p_res[k]) << (N - k)) + (SQ_W'(1) << (2 * (N - 1 - k)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < N; k++)
                if (rdy[k])
                    v_reg[k] <= p_v[k];
        end
    end

    // One root bit per stage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (rdy[k] && p_v[k])
            begin
                side_reg[k] <= p_side[k];
                if (p_rem[k] >= inc[k])
                begin
                    rem_reg[k] <= p_rem[k] - inc[k];
                    res_reg[k] <= p_res[k] | (ROOT_W'(1) << (N - 1 - k));
                end
                else
                begin
                    rem_reg[k] <= p_rem[k];
                    res_reg[k] <= p_res[k];
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign out_root  = res_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// File: hw/rtl/rm2q_div.sv
module rm2q_div
    import rm2q_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ROOT_W-1:0] in_root,
    input  rm2q_side_t        in_side,
    output logic              out_valid,
    output rm2q_quo_t         out_quo,
    input  logic              out_ready
);

    localparam int N = QB;

    logic [N-1:0]                  v_reg;
    logic [LANES-1:0][CMP_W-1:0]   rem_reg [N];
    rm2q_quo_t                     quo_reg [N];

    logic [N:0]                    rdy;
    logic [N-1:0]                  p_v;
    logic [LANES-1:0][CMP_W-1:0]   p_rem   [N];
    rm2q_quo_t                     p_quo   [N];
    logic [CMP_W-1:0]              dsh     [N];
    logic [CMP_W-1:0]              s_ext;
    logic [LANES-1:0][CMP_W-1:0]   rem_next [N];
    rm2q_quo_t                     quo_next [N];

    always_comb
    begin
        rdy[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    // First stage takes the scaled numerators and checks for quotient overflow
    always_comb
    begin
        s_ext         = CMP_W'({in_root, 1'b0});
        p_v[0]        = in_valid;
        p_quo[0].branch = in_side.branch;
        p_quo[0].nonpos = in_side.nonpos;
        p_quo[0].root   = in_root;
        p_quo[0].neg    = in_side.neg;
        p_quo[0].q      = '0;
        for (int l = 0; l < LANES; l++)
        begin
            p_rem[0][l]     = CMP_W'({in_side.mag[l], {FRAC_BITS{1'b0}}});
            p_quo[0].ovf[l] = (p_rem[0][l] >= (s_ext << QB));
        end
        for (int k = 1; k < N; k++)
        begin
            p_v[k]   = v_reg[k-1];
            p_rem[k] = rem_reg[k-1];
            p_quo[k] = quo_reg[k-1];
        end
        for (int k = 0; k < N; k++)
            dsh[k] = CMP_W'({p_quo[k].root, 1'b0}) << (N - 1 - k);

        // One quotient bit per stage in each lane
        for (int k = 0; k < N; k++)
        begin
            quo_next[k] = p_quo[k];
            for (int l = 0; l < LANES; l++)
            begin
                if (p_rem[k][l] >= dsh[k])
                begin
                    rem_next[k][l]   = p_rem[k][l] - dsh[k];
                    quo_next[k].q[l] = p_quo[k].q[l] | (QB'(1) << (N - 1 - k));
                end
                else
                    rem_next[k][l] = p_rem[k][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < N; k++)
                if (rdy[k])
                    v_reg[k] <= p_v[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (rdy[k] && p_v[k])
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign out_quo   = quo_reg[N-1];

endmodule

// File: hw/rtl/rm2q_out.sv
module rm2q_out
    import rm2q_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rm2q_quo_t                    in_quo,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] quat_x,
    output logic signed [DATA_WIDTH-1:0] quat_y,
    output logic signed [DATA_WIDTH-1:0] quat_z,
    output logic signed [DATA_WIDTH-1:0] quat_w,
    output logic [1:0]                   branch_taken,
    output logic                         degenerate
);

    localparam int XW = ROOT_W + DATA_WIDTH;
    localparam logic [QB-1:0] MAXP = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] MINM = {1'b1, {(QB-1){1'b0}}};

    logic                  v_reg;
    logic [DATA_WIDTH-1:0] x_reg, y_reg, z_reg, w_reg;
    logic [1:0]            br_reg;
    logic                  dg_reg;

    logic [DATA_WIDTH-1:0] c    [LANES];
    logic [DATA_WIDTH-1:0] qc;
    logic [XW-1:0]         half;
    logic [DATA_WIDTH-1:0] x_next, y_next, z_next, w_next;
    logic                  dg_next;

    // Saturate sign and magnitude to a signed code
    function automatic logic [DATA_WIDTH-1:0] sat_q(input logic neg, input logic ovf,
                                                     input logic [QB-1:0] q);
        logic [QB-1:0] lim;
        if (neg)
        begin
            lim = (ovf || q > MINM) ? MINM : q;
            return DATA_WIDTH'(-lim);
        end
        lim = (ovf || q > MAXP) ? MAXP : q;
        return DATA_WIDTH'(lim);
    endfunction

    assign in_ready = !v_reg || !out_stall;

    // Component codes and placement by branch
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            c[l] = sat_q(in_quo.neg[l], in_quo.ovf[l], in_quo.q[l]);
        half = XW'(in_quo.root >> 1);
        qc   = (half > XW'(MAXP)) ? DATA_WIDTH'(MAXP) : DATA_WIDTH'(half);
        case (in_quo.branch)
            BR_TRACE: begin x_next = c[0]; y_next = c[1]; z_next = c[2]; w_next = qc;   end
            BR_X:     begin x_next = qc;   y_next = c[0]; z_next = c[1]; w_next = c[2]; end
            BR_Y:     begin x_next = c[0]; y_next = qc;   z_next = c[1]; w_next = c[2]; end
            default:  begin x_next = c[0]; y_next = c[1]; z_next = qc;   w_next = c[2]; end
        endcase
        dg_next = in_quo.nonpos || (in_quo.root == '0);
        if (dg_next)
        begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
            w_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            w_reg  <= w_next;
            br_reg <= in_quo.branch;
            dg_reg <= dg_next;
        end
    end

    assign out_valid    = v_reg;
    assign quat_x       = x_reg;
    assign quat_y       = y_reg;
    assign quat_z       = z_reg;
    assign quat_w       = w_reg;
    assign branch_taken = br_reg;
    assign degenerate   = dg_reg;

    // Degenerate results carry all-zero components
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
        else $error("degenerate result with nonzero component");

    // The root-derived component is never negative
    a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_TRACE |-> !quat_w[DATA_WIDTH-1])
        else $error("negative w on trace path");

    a_z_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_Z |-> !quat_z[DATA_WIDTH-1])
        else $error("negative z on z branch");

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion, Shepperd's method.
// Pipeline: 1 radicand stage, ROOT_W=16 root stages, QB=16 divide stages, 1 output stage.
// Throughput: one matrix per cycle while out_stall is low; a full stage holds while its successor cannot move.
// The bit-serial root and the three-lane restoring divider set the depth.
// Reset (rst_n, async low) clears stage valid bits and sets eps_reg (trace epsilon) to 0.
module rotation_matrix_to_quaternion_unit
    import rm2q_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [EPS_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] quat_x,
    output logic signed [DATA_WIDTH-1:0] quat_y,
    output logic signed [DATA_WIDTH-1:0] quat_z,
    output logic signed [DATA_WIDTH-1:0] quat_w,
    output logic [1:0]                   branch_taken,
    output logic                         degenerate
);

    logic [EPS_W-1:0]  eps_reg;
    logic              fr_ready, fr_valid;
    logic [V_W-1:0]    fr_rad;
    rm2q_side_t        fr_side;
    logic              sq_ready, sq_valid;
    logic [ROOT_W-1:0] sq_root;
    rm2q_side_t        sq_side;
    logic              dv_ready, dv_valid;
    rm2q_quo_t         dv_quo;
    logic              op_ready;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= '0;
        else if (cfg_valid && cfg_ready)
            eps_reg <= cfg_data;
    end

    assign in_stall = !fr_ready;

    rm2q_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (fr_ready),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22),
        .eps       (eps_reg),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_side  (fr_side),
        .out_ready (sq_ready)
    );

    rm2q_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (sq_ready),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side),
        .out_ready (dv_ready)
    );

    rm2q_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (dv_ready),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ready (op_ready)
    );

    rm2q_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dv_valid),
        .in_ready     (op_ready),
        .in_quo       (dv_quo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .branch_taken (branch_taken),
        .degenerate   (degenerate)
    );

endmodule

// File: bench/tb_rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 100ps

// Expected quaternions for matrices accepted by the converter
class quat_scoreboard;
    typedef struct {
        logic signed [15:0] qx, qy, qz, qw;
        logic [1:0]         br;
        logic               degen;
    } quat_t;

    quat_t       pending[$];
    logic [14:0] eps;
    int          errors;

    function new();
        eps    = '0;
        errors = 0;
    endfunction

    // Saturate sign and magnitude to 16 bits
    function logic signed [15:0] sat16(bit neg, longint unsigned mag);
        if (neg) begin
            if (mag > 64'd32768) mag = 64'd32768;
            return 16'(-longint'(mag));
        end
        if (mag > 64'd32767) mag = 64'd32767;
        return 16'(mag);
    endfunction

    function logic signed [15:0] fix_div(longint num, longint unsigned s);
        bit              neg;
        longint unsigned mag;
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        mag = mag << rm2q_pkg::FRAC_BITS;
        return sat16(neg, mag / s);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Note an accepted matrix and predict its quaternion
    function void note_matrix(logic signed [15:0] m[9]);
        longint          a[9];
        longint          one, t, rad;
        longint unsigned root, s;
        quat_t           e;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        one = 64'd1 << rm2q_pkg::FRAC_BITS;
        t   = a[0] + a[4] + a[8] + one;
        e   = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, rm2q_pkg::BR_TRACE, 1'b0};
        if (t > longint'(eps))
        begin
            e.br = rm2q_pkg::BR_TRACE; rad = t;
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            e.br = rm2q_pkg::BR_X; rad = one + a[0] - a[4] - a[8];
        end
        else if (a[4] > a[8])
        begin
            e.br = rm2q_pkg::BR_Y; rad = one + a[4] - a[0] - a[8];
        end
        else
        begin
            e.br = rm2q_pkg::BR_Z; rad = one + a[8] - a[0] - a[4];
        end
        if (rad <= 0)
            e.degen = 1'b1;
        else
        begin
            root = int_sqrt(longint'(rad) << rm2q_pkg::FRAC_BITS);
            s    = root * 2;
            if (s == 0)
                e.degen = 1'b1;
            else
            begin
                case (e.br)
                    rm2q_pkg::BR_TRACE:
                    begin
                        e.qx = fix_div(a[7] - a[5], s);
                        e.qy = fix_div(a[2] - a[6], s);
                        e.qz = fix_div(a[3] - a[1], s);
                        e.qw = sat16(0, root >> 1);
                    end
                    rm2q_pkg::BR_X:
                    begin
                        e.qx = sat16(0, root >> 1);
                        e.qy = fix_div(a[1] + a[3], s);
                        e.qz = fix_div(a[2] + a[6], s);
                        e.qw = fix_div(a[7] - a[5], s);
                    end
                    rm2q_pkg::BR_Y:
                    begin
                        e.qx = fix_div(a[1] + a[3], s);
                        e.qy = sat16(0, root >> 1);
                        e.qz = fix_div(a[5] + a[7], s);
                        e.qw = fix_div(a[2] - a[6], s);
                    end
                    default:
                    begin
                        e.qx = fix_div(a[2] + a[6], s);
                        e.qy = fix_div(a[5] + a[7], s);
                        e.qz = sat16(0, root >> 1);
                        e.qw = fix_div(a[3] - a[1], s);
                    end
                endcase
            end
        end
        pending.push_back(e);
    endfunction

    function void report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endfunction

    // Compare one result transaction against the oldest expectation
    function void check_quat(quat_t r);
        quat_t e;
        if (pending.size() == 0)
        begin
            report("unexpected result", 1, 0);
            return;
        end
        e = pending.pop_front();
        if (r.qx !== e.qx) report("quat_x", r.qx, e.qx);
        if (r.qy !== e.qy) report("quat_y", r.qy, e.qy);
        if (r.qz !== e.qz) report("quat_z", r.qz, e.qz);
        if (r.qw !== e.qw) report("quat_w", r.qw, e.qw);
        if (r.br !== e.br) report("branch_taken", r.br, e.br);
        if (r.degen !== e.degen) report("degenerate", r.degen, e.degen);
    endfunction
endclass

module tb_rotation_matrix_to_quaternion_unit;
    import rm2q_pkg::*;

    localparam int LATENCY = 34;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [EPS_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [DATA_WIDTH-1:0] mat[9];
    logic signed [DATA_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;
    logic [1:0] branch_taken;
    logic degenerate;

    quat_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    bit  hold_off;

    rotation_matrix_to_quaternion_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(mat[0]), .m01(mat[1]), .m02(mat[2]),
        .m10(mat[3]), .m11(mat[4]), .m12(mat[5]),
        .m20(mat[6]), .m21(mat[7]), .m22(mat[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .branch_taken(branch_taken), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Receiver: random stall, forced high during a hold-off
    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // Check results at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_quat('{quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate});

    // Offer one matrix, hold it until accepted
    task automatic send_matrix(logic signed [15:0] m[9]);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        mat      = m;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_matrix(m);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_eps(logic [14:0] v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.eps = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // Random matrix: mostly near-rotation shapes, some fully random
    task automatic send_random();
        logic signed [15:0] m[9];
        int k;
        k = $urandom_range(9);
        for (int i = 0; i < 9; i++)
        begin
            if (k < 3) m[i] = rnd16();
            else m[i] = 16'($signed($urandom_range(32768)) - 16384);
        end
        if (k == 9)
        begin
            // push toward low trace so the diagonal branches fire
            m[$urandom_range(2) * 4] = 16'sd16384;
            m[0] = -m[0];
        end
        send_matrix(m);
    endtask

    initial
    begin
        logic signed [15:0] d[9];
        logic [14:0] eps_set[4];
        sb = new();
        rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = '0; in_valid = 1'b0;
        hold_off = 1'b0; out_stall = 1'b0;
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 9; i++) mat[i] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: identity, rotations about each axis, extremes, ties, degenerate
        d = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(d);
        d = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(d);
        d = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(d);
        d = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(d);
        d = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(d);
        d = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(d);
        d = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_matrix(d);
        d = '{-16384, 1, -1, 1, -16384, 1, -1, 1, -16384}; send_matrix(d);
        d = '{-8192, 32767, 32767, -32768, -8192, 32767, -32768, -32768, -8192};
        send_matrix(d);
        d = '{-16383, 5, 5, 5, -16383, 5, 5, 5, -16384}; send_matrix(d);
        d = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(d);
        d = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(d);
        drain();

        eps_set = '{15'h7FFF, 15'd16384, 15'd1, 15'd0};
        foreach (eps_set[p])
        begin
            write_eps(eps_set[p]);
            d = '{0, 100, -200, 300, 0, -32768, 32767, 5, 0}; send_matrix(d);
            d = '{8192, 0, 0, 0, -4096, 0, 0, 0, -4096}; send_matrix(d);
            d = '{-32768, 0, 0, 0, -32768, 0, 0, 0, 32767}; send_matrix(d);
            drain();
        end

        // Random phases with varying epsilon and idling
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 68 : 0;
            recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 8 : 0;
            write_eps((ph == 2) ? 15'h7FFF : 15'($urandom_range(32767)));
            for (int n = 0; n < 270; n++)
            begin
                if (ph == 2 && n == 40)
                begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (200) @(negedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (n == 150)
                    while (sb.pending.size() != 0) @(negedge clk);
                send_random();
            end
            drain();
        end
        write_eps(15'd0);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
